>>> src/blob_track_table_macros.svh
// Assertion helpers for the track table.
// Each check samples on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef BLOB_TRACK_TABLE_MACROS_SVH
`define BLOB_TRACK_TABLE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define BTT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blob_track_table: same-cycle check failed");
// Next-cycle implication
`define BTT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blob_track_table: next-cycle check failed");
`else
`define BTT_ASSERT_IMP(label, ante, cons)
`define BTT_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> src/btt_pkg.sv
`default_nettype none

package btt_pkg;

    localparam int MAX_TARGETS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam logic [31:0] THRESH_RESET = 32'd1000000;

    // operation codes
    localparam logic [1:0] OP_BLOB   = 2'd0;
    localparam logic [1:0] OP_FRAME  = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // status codes
    localparam logic [2:0] ST_MATCHED    = 3'd0;
    localparam logic [2:0] ST_NEW_ENTRY  = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_FRAME_DONE = 3'd3;
    localparam logic [2:0] ST_UPDATED    = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] diameter;
        logic [11:0] rect_width;
        logic [11:0] rect_height;
        logic [3:0]  entry_select;
        logic [31:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] entry_index;
        logic [4:0] pruned_count;
        logic [4:0] live_count;
    } t_out_item;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] w;
        logic [11:0] h;
    } t_rect;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> src/btt_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module btt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/blob_track_table.sv
// Ordered table of tracked rectangles. A blob word (operation 0) pairs with the first
// entry, in table order, that is neither paired nor newly created this frame and whose
// rectangle holds the blob center; otherwise it appends a new square entry cornered at
// the blob center, or is dropped with status 2 when the table is full. An end-of-frame
// word (operation 1) removes every unpaired, non-new entry whose modulo age has reached
// prune_threshold, compacts the rest in order and clears all marks. An update word
// (operation 2) rewrites one live entry's rectangle. Operation 3 is ignored and yields
// no result. Every other word yields exactly one result word. Timing: one word is in
// work at a time; the entry memory has a single registered read port, so each entry
// visited takes an address step, then an evaluate step. An update visits no entry; a
// blob or end of frame visits at most MAX_TARGETS entries. o_ready rises again in the
// same cycle that the result word appears on the output. A finished result sits in an
// output register, so the next word is accepted while it waits to be taken; a word that
// finishes while that register is still full holds in its last step until the register
// frees. The user must write prune_threshold through i_cfg_we / i_cfg_data only while
// the block is idle; the block itself does not enforce this. No clearing pass runs
// after reset; entries past the live count are never evaluated.
`default_nettype none

`include "blob_track_table_macros.svh"

module blob_track_table
    import btt_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    // result words
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_result,
    // threshold register
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW   = $clog2(MAX_TARGETS);        // table index width
    localparam int CW   = $clog2(MAX_TARGETS + 1);    // entry count width
    localparam int SW   = (CW > 4) ? CW : 4;          // select compare width
    localparam int CMPW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int RW   = $bits(t_rect);

    // control state
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [MAX_TARGETS-1:0] r_paired, n_paired;
    logic [MAX_TARGETS-1:0] r_fresh, n_fresh;
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_thresh;

    // working registers
    t_in_item               r_item, n_item;
    logic [IW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_keep, n_keep;
    logic [CW-1:0]          r_pruned, n_pruned;
    t_out_item              r_res, n_res;
    t_out_item              r_out, n_out;

    // entry memory ports
    logic                   w_we_rect, w_we_time;
    logic [IW-1:0]          w_waddr;
    t_rect                  w_wrect;
    logic [TIME_BITS-1:0]   w_wtime;
    logic [RW-1:0]          w_rd_rect_bits;
    t_rect                  w_rd_rect;
    logic [TIME_BITS-1:0]   w_rd_time;

    // evaluation
    logic [TIME_BITS-1:0]   w_now;
    logic [TIME_BITS-1:0]   w_age;
    logic                   w_inside;
    logic                   w_skip;
    logic                   w_last;
    logic                   w_prune;
    logic                   w_append;

    // Rectangles and timestamps live apart so a match stamps time only
    // and an update rewrites the rectangle only.
    btt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_TARGETS)
    ) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_rect),
        .i_waddr (w_waddr),
        .i_wdata (w_wrect),
        .i_raddr (r_idx),
        .o_rdata (w_rd_rect_bits)
    );

    btt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_TARGETS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_time),
        .i_waddr (w_waddr),
        .i_wdata (w_wtime),
        .i_raddr (r_idx),
        .o_rdata (w_rd_time)
    );

    assign w_rd_rect = t_rect'(w_rd_rect_bits);

    // Timestamp reduced modulo 2^TIME_BITS (zero-extended when wider).
    assign w_now = TIME_BITS'({{TIME_BITS{1'b0}}, r_item.current_time});
    assign w_age = w_now - w_rd_time;

    // Half-open containment; a zero side holds no point.
    assign w_inside = (w_rd_rect.left <= r_item.pos_x)
        && ({1'b0, r_item.pos_x} < ({1'b0, w_rd_rect.left} + {1'b0, w_rd_rect.w}))
        && (w_rd_rect.top <= r_item.pos_y)
        && ({1'b0, r_item.pos_y} < ({1'b0, w_rd_rect.top} + {1'b0, w_rd_rect.h}));

    assign w_skip  = r_paired[r_idx] | r_fresh[r_idx];
    assign w_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_prune = !w_skip && (CMPW'(w_age) >= CMPW'(r_thresh));

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_paired    = r_paired;
        n_fresh     = r_fresh;
        n_item      = r_item;
        n_idx       = r_idx;
        n_keep      = r_keep;
        n_pruned    = r_pruned;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        w_we_rect   = 1'b0;
        w_we_time   = 1'b0;
        w_waddr     = r_idx;
        w_wrect     = w_rd_rect;
        w_wtime     = w_rd_time;
        w_append    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item  = i_item;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_idx    = '0;
                n_keep   = '0;
                n_pruned = '0;
                priority if (r_item.operation == OP_BLOB) begin
                    if (r_count == '0) begin
                        w_append = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (r_item.operation == OP_FRAME) begin
                    if (r_count == '0) begin
                        n_paired = '0;
                        n_fresh  = '0;
                        n_res    = '{ST_FRAME_DONE, 4'd0, 5'd0, 5'd0};
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (r_item.operation == OP_UPDATE) begin
                    if (SW'(r_item.entry_select) < SW'(r_count)) begin
                        w_we_rect = 1'b1;
                        w_waddr   = IW'(r_item.entry_select);
                        w_wrect   = '{r_item.pos_x, r_item.pos_y,
                                      r_item.rect_width, r_item.rect_height};
                        n_res     = '{ST_UPDATED, r_item.entry_select, 5'd0,
                                      5'(r_count)};
                    end else begin
                        n_res = '{ST_BAD_INDEX, r_item.entry_select, 5'd0, 5'(r_count)};
                    end
                    n_state = S_DONE;
                end else begin
                    // reserved code: drop without a result
                    n_state = S_IDLE;
                end
            end

            S_READ: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                if (r_item.operation == OP_BLOB) begin
                    if (!w_skip && w_inside) begin
                        w_we_time       = 1'b1;
                        w_waddr         = r_idx;
                        w_wtime         = w_now;
                        n_paired[r_idx] = 1'b1;
                        n_res           = '{ST_MATCHED, 4'(r_idx), 5'd0, 5'(r_count)};
                        n_state         = S_DONE;
                    end else if (w_last) begin
                        w_append = 1'b1;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    // compact: survivors move down to the keep slot
                    if (!w_prune) begin
                        w_we_rect = 1'b1;
                        w_we_time = 1'b1;
                        w_waddr   = IW'(r_keep);
                        n_keep    = r_keep + 1'b1;
                    end else begin
                        n_pruned = r_pruned + 1'b1;
                    end
                    if (w_last) begin
                        n_count  = n_keep;
                        n_paired = '0;
                        n_fresh  = '0;
                        n_res    = '{ST_FRAME_DONE, 4'd0, 5'(n_pruned), 5'(n_keep)};
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end

            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append a new entry at the tail, or drop when full.
        if (w_append) begin
            if (r_count >= CW'(MAX_TARGETS)) begin
                n_res = '{ST_DROPPED, 4'd0, 5'd0, 5'(r_count)};
            end else begin
                w_we_rect                = 1'b1;
                w_we_time                = 1'b1;
                w_waddr                  = IW'(r_count);
                w_wrect                  = '{r_item.pos_x, r_item.pos_y,
                                             r_item.diameter, r_item.diameter};
                w_wtime                  = w_now;
                n_paired[IW'(r_count)]   = 1'b0;
                n_fresh[IW'(r_count)]    = 1'b1;
                n_count                  = r_count + 1'b1;
                n_res                    = '{ST_NEW_ENTRY, 4'(r_count), 5'd0,
                                             5'(r_count + 1'b1)};
            end
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_paired    <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_paired    <= n_paired;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_idx    <= n_idx;
        r_keep   <= n_keep;
        r_pruned <= n_pruned;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    `BTT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_TARGETS))
    `BTT_ASSERT_IMP(a_scan_in_range, r_state == S_EVAL, CW'(r_idx) < r_count)
    `BTT_ASSERT_IMP(a_keep_behind_scan,
        (r_state == S_EVAL) && (r_item.operation == OP_FRAME), r_keep <= CW'(r_idx))
    `BTT_ASSERT_IMP(a_frame_clears_marks,
        (r_state == S_DONE) && (r_item.operation == OP_FRAME),
        (r_paired == '0) && (r_fresh == '0))
    `BTT_ASSERT_NXT(a_done_publishes,
        (r_state == S_DONE) && (!r_out_valid || i_ready),
        r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire
